@@ hdl/ock_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ock_pkg
// Shared types and constants for the omni chassis kinematics block.
// ----------------------------------------------------------------------------
package ock_pkg;

   localparam int OCK_LANES    = 4;
   localparam int OCK_OPND_W   = 42;   // lane operand, scaled by 2^24 shift
   localparam int OCK_SPLIT    = 24;   // low part of the operand
   localparam int OCK_RES_W    = 52;   // lane product after the shift
   localparam int OCK_HWB_W    = 20;
   localparam int OCK_LIM_W    = 31;
   localparam int OCK_ADDR_W   = 5;

   localparam logic [OCK_LIM_W-1:0] SPEED_LIMIT_RESET = 31'd2304000;

   typedef enum logic [2:0] {
      REG_INV_GAIN  = 3'd0,
      REG_LIN_GAIN  = 3'd1,
      REG_ROT_GAIN  = 3'd2,
      REG_HALF_WB   = 3'd3,
      REG_SPEED_LIM = 3'd4
   } ock_reg_type;

   typedef enum logic {
      KIND_INVERSE = 1'b0,
      KIND_FORWARD = 1'b1
   } ock_kind_type;

   typedef struct packed {
      logic [31:0]          inv_gain;
      logic [31:0]          lin_gain;
      logic [31:0]          rot_gain;
      logic [OCK_HWB_W-1:0] half_wb;
      logic [OCK_LIM_W-1:0] speed_lim;
   } ock_cfg_type;

   typedef struct packed {
      logic load_part;
      logic load_sum;
   } ock_lane_ctl_type;

endpackage
`default_nettype wire

@@ hdl/omni_chassis_kinematics_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// omni_chassis_kinematics_top
// Omni X-drive chassis kinematics: chassis velocity to four wheel speeds
// (inverse) or four wheel speeds to chassis velocity (forward).
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while rsp_tready is high; each of the six
// pipeline stages is a single register step, the longest being the lane
// multipliers (18x33 and 24x32). Empty stages collapse, so req is still
// taken while a result waits on rsp, until every stage holds a word.
// Reset: synchronous; clears all stage valids and loads the register reset
// values (gains and half wheelbase zero, speed limit 9000 rpm).
// ----------------------------------------------------------------------------
module omni_chassis_kinematics_top (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata, low bit up: vel_x, vel_y, yaw_rate, speed_in_0..speed_in_3
   input  wire logic [223:0] req_tdata,
   // tuser: kind
   input  wire logic [0:0]   req_tuser,
   // response stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // tdata, low bit up: speed_out_0..speed_out_3, est_vel_x, est_vel_y,
   // est_yaw_rate
   output logic [223:0]      rsp_tdata,
   // configuration port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import ock_pkg::*;

   localparam int STAGES = 6;
   localparam int T_W    = 38;   // turn term after the Q16.16 realignment
   localparam int FS_W   = 34;   // forward four-term sum

   ock_cfg_type cfg;

   // valid per stage and the load enables; a stage loads when it is empty
   // or the stage after it loads
   logic [STAGES:1] vld_ff;
   logic [STAGES:1] vld_in;
   logic [STAGES:1] ld;

   always_comb begin
      ld[STAGES] = ~vld_ff[STAGES] | rsp_tready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         ld[k] = ~vld_ff[k] | ld[k+1];
      end
      vld_in = vld_ff;
      if (ld[1]) vld_in[1] = req_tvalid;
      for (int k = 2; k <= STAGES; k++) begin
         if (ld[k]) vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = ld[1];

   ock_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------- stage 1: capture the request word ----------------
   logic               kind1_ff;
   logic signed [31:0] vx1_ff, vy1_ff, wz1_ff;
   logic signed [31:0] sp1_ff [OCK_LANES];

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         kind1_ff <= req_tuser[0];
         vx1_ff   <= req_tdata[31:0];
         vy1_ff   <= req_tdata[63:32];
         wz1_ff   <= req_tdata[95:64];
         for (int i = 0; i < OCK_LANES; i++) begin
            sp1_ff[i] <= req_tdata[96 + 32*i +: 32];
         end
      end
   end

   // ------- stage 2: yaw rate times half wheelbase, forward sums -------
   logic                  kind2_ff;
   logic signed [31:0]    vx2_ff, vy2_ff;
   logic signed [52:0]    turn2_ff;
   logic signed [52:0]    turn2_in;
   logic signed [FS_W-1:0] fx2_ff, fy2_ff, fw2_ff;
   logic signed [FS_W-1:0] fx2_in, fy2_in, fw2_in;
   logic signed [FS_W-1:0] rr_e, lr_e, fl_e, fr_e;

   assign rr_e = FS_W'(sp1_ff[0]);
   assign lr_e = FS_W'(sp1_ff[1]);
   assign fl_e = FS_W'(sp1_ff[2]);
   assign fr_e = FS_W'(sp1_ff[3]);

   assign turn2_in = wz1_ff * $signed({1'b0, cfg.half_wb});
   assign fx2_in   = fr_e + fl_e - lr_e - rr_e;
   assign fy2_in   = lr_e + fl_e - rr_e - fr_e;
   assign fw2_in   = lr_e + rr_e + fr_e + fl_e;

   always_ff @(posedge clock) begin
      if (ld[2]) begin
         kind2_ff <= kind1_ff;
         vx2_ff   <= vx1_ff;
         vy2_ff   <= vy1_ff;
         turn2_ff <= turn2_in;
         fx2_ff   <= fx2_in;
         fy2_ff   <= fy2_in;
         fw2_ff   <= fw2_in;
      end
   end

   // ------------- stage 3: lane operands and gains -------------
   logic                          kind3_ff;
   logic signed [OCK_OPND_W-1:0]  op3_ff [OCK_LANES];
   logic signed [OCK_OPND_W-1:0]  op3_in [OCK_LANES];
   logic [31:0]                   gain3_ff [OCK_LANES];
   logic [31:0]                   gain3_in [OCK_LANES];
   logic signed [T_W-1:0]         turn;
   logic signed [OCK_OPND_W-1:0]  t_e, vx_e, vy_e;

   // 2*wz*a realigned to Q16.16: drop 15 bits, rounding toward minus infinity
   assign turn = turn2_ff[52:15];
   assign t_e  = OCK_OPND_W'(turn);
   assign vx_e = OCK_OPND_W'(vx2_ff);
   assign vy_e = OCK_OPND_W'(vy2_ff);

   always_comb begin
      if (kind2_ff == KIND_INVERSE) begin
         // lanes in bus order: rear right, rear left, front left, front right
         op3_in[0] = -vx_e - vy_e - t_e;
         op3_in[1] = -vx_e + vy_e - t_e;
         op3_in[2] =  vx_e + vy_e - t_e;
         op3_in[3] =  vx_e - vy_e - t_e;
         for (int i = 0; i < OCK_LANES; i++) gain3_in[i] = cfg.inv_gain;
      end else begin
         // shift forward sums up 8 so the lane's 2^24 scale acts as 2^16
         op3_in[0]   = {fx2_ff, 8'h00};
         op3_in[1]   = {fy2_ff, 8'h00};
         op3_in[2]   = {fw2_ff, 8'h00};
         op3_in[3]   = '0;
         gain3_in[0] = cfg.lin_gain;
         gain3_in[1] = cfg.lin_gain;
         gain3_in[2] = cfg.rot_gain;
         gain3_in[3] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld[3]) begin
         kind3_ff <= kind2_ff;
         op3_ff   <= op3_in;
         gain3_ff <= gain3_in;
      end
   end

   // ---------- stages 4 and 5: multiply lanes ----------
   logic                         kind4_ff, kind5_ff;
   ock_lane_ctl_type             lane_ctl;
   logic signed [OCK_RES_W-1:0]  lane_res [OCK_LANES];

   assign lane_ctl.load_part = ld[4];
   assign lane_ctl.load_sum  = ld[5];

   always_ff @(posedge clock) begin
      if (ld[4]) kind4_ff <= kind3_ff;
      if (ld[5]) kind5_ff <= kind4_ff;
   end

   for (genvar g = 0; g < OCK_LANES; g++) begin : g_lane
      ock_lane u_lane (
         .clock (clock),
         .ctl   (lane_ctl),
         .opnd  (op3_ff[g]),
         .gain  (gain3_ff[g]),
         .res   (lane_res[g])
      );
   end

   // ---------- stage 6: merge, clamp and hold the response ----------
   logic [31:0]  speed_m [OCK_LANES];
   logic [31:0]  est_m [3];
   logic [223:0] rsp_data_ff;
   logic [223:0] rsp_data_in;

   ock_merge u_merge (
      .kind      (kind5_ff),
      .speed_lim (cfg.speed_lim),
      .lane_res  (lane_res),
      .speed_out (speed_m),
      .est_out   (est_m)
   );

   assign rsp_data_in = {est_m[2], est_m[1], est_m[0],
                         speed_m[3], speed_m[2], speed_m[1], speed_m[0]};

   always_ff @(posedge clock) begin
      if (ld[STAGES]) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = vld_ff[STAGES];
   assign rsp_tdata  = rsp_data_ff;

   // ---------------- checks ----------------
   // never both groups populated in one result
   a_group_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[127:0] == '0 || rsp_tdata[223:128] == '0))
      else $error("speed and estimate groups both nonzero");

   // every wheel speed stays within the configured limit
   a_speed_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[31:0])   <= $signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[31:0])   >= -$signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[63:32])  <= $signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[63:32])  >= -$signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[95:64])  <= $signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[95:64])  >= -$signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[127:96]) <= $signed({1'b0, cfg.speed_lim}) &&
          $signed(rsp_tdata[127:96]) >= -$signed({1'b0, cfg.speed_lim})))
      else $error("wheel speed outside limit");

   // an accepted word always occupies the first stage next cycle
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[1])
      else $error("accepted word lost at stage 1");

   // a full last-but-one stage moving on always yields a response
   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && ld[STAGES]) |=> rsp_tvalid)
      else $error("word dropped between lanes and output");

endmodule
`default_nettype wire

@@ hdl/ock_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ock_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module ock_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [ock_pkg::OCK_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output ock_pkg::ock_cfg_type              cfg
);
   import ock_pkg::*;

   ock_cfg_type cfg_ff;
   ock_cfg_type cfg_in;
   ock_reg_type idx;
   logic        wr_en;

   assign idx        = ock_reg_type'(csr_paddr[OCK_ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_INV_GAIN:  cfg_in.inv_gain  = csr_pwdata;
            REG_LIN_GAIN:  cfg_in.lin_gain  = csr_pwdata;
            REG_ROT_GAIN:  cfg_in.rot_gain  = csr_pwdata;
            REG_HALF_WB:   cfg_in.half_wb   = csr_pwdata[OCK_HWB_W-1:0];
            REG_SPEED_LIM: cfg_in.speed_lim = csr_pwdata[OCK_LIM_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inv_gain  <= '0;
         cfg_ff.lin_gain  <= '0;
         cfg_ff.rot_gain  <= '0;
         cfg_ff.half_wb   <= '0;
         cfg_ff.speed_lim <= SPEED_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_INV_GAIN:  csr_prdata = cfg_ff.inv_gain;
         REG_LIN_GAIN:  csr_prdata = cfg_ff.lin_gain;
         REG_ROT_GAIN:  csr_prdata = cfg_ff.rot_gain;
         REG_HALF_WB:   csr_prdata = {{(32-OCK_HWB_W){1'b0}}, cfg_ff.half_wb};
         REG_SPEED_LIM: csr_prdata = {{(32-OCK_LIM_W){1'b0}}, cfg_ff.speed_lim};
         default:       csr_prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

@@ hdl/ock_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ock_lane
// One multiply lane: floor(operand * gain / 2^24) in two stages.
// ----------------------------------------------------------------------------
module ock_lane (
   input  wire logic                                clock,
   input  wire ock_pkg::ock_lane_ctl_type           ctl,
   input  wire logic signed [ock_pkg::OCK_OPND_W-1:0] opnd,
   input  wire logic [31:0]                         gain,
   output logic signed [ock_pkg::OCK_RES_W-1:0]     res
);
   import ock_pkg::*;

   localparam int HI_W = OCK_OPND_W - OCK_SPLIT;

   logic signed [HI_W-1:0]       op_hi;
   logic [OCK_SPLIT-1:0]         op_lo;
   logic signed [HI_W+32:0]      hi_prod_ff;
   logic signed [HI_W+32:0]      hi_prod_in;
   logic [OCK_SPLIT+31:0]        lo_prod_ff;
   logic [OCK_SPLIT+31:0]        lo_prod_in;
   logic signed [OCK_RES_W-1:0]  res_ff;
   logic signed [OCK_RES_W-1:0]  res_in;

   // split the operand: high part signed, low part unsigned
   assign op_hi      = opnd[OCK_OPND_W-1:OCK_SPLIT];
   assign op_lo      = opnd[OCK_SPLIT-1:0];
   assign hi_prod_in = op_hi * $signed({1'b0, gain});
   assign lo_prod_in = {{32{1'b0}}, op_lo} * {{OCK_SPLIT{1'b0}}, gain};

   // low product is nonnegative, so its shifted part folds in exactly
   assign res_in = OCK_RES_W'(hi_prod_ff)
                 + $signed({{(OCK_RES_W-32){1'b0}}, lo_prod_ff[OCK_SPLIT+31:OCK_SPLIT]});

   always_ff @(posedge clock) begin
      if (ctl.load_part) begin
         hi_prod_ff <= hi_prod_in;
         lo_prod_ff <= lo_prod_in;
      end
      if (ctl.load_sum) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule
`default_nettype wire

@@ hdl/ock_merge.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ock_merge
// Combine lane products into one result word: clamp wheel speeds or
// saturate velocity estimates, zero the unused group.
// ----------------------------------------------------------------------------
module ock_merge (
   input  wire logic                                 kind,
   input  wire logic [ock_pkg::OCK_LIM_W-1:0]        speed_lim,
   input  wire logic signed [ock_pkg::OCK_RES_W-1:0] lane_res [ock_pkg::OCK_LANES],
   output logic [31:0]                               speed_out [ock_pkg::OCK_LANES],
   output logic [31:0]                               est_out [3]
);
   import ock_pkg::*;

   localparam logic signed [OCK_RES_W-1:0] S32_MAX = OCK_RES_W'(64'sh7FFF_FFFF);
   localparam logic signed [OCK_RES_W-1:0] S32_MIN = -OCK_RES_W'(64'sh8000_0000);

   logic signed [OCK_RES_W-1:0] lim_pos;
   logic signed [OCK_RES_W-1:0] lim_neg;
   logic signed [OCK_RES_W-1:0] clamped [OCK_LANES];
   logic signed [OCK_RES_W-1:0] sat [3];

   assign lim_pos = $signed({{(OCK_RES_W-OCK_LIM_W){1'b0}}, speed_lim});
   assign lim_neg = -lim_pos;

   always_comb begin
      for (int i = 0; i < OCK_LANES; i++) begin
         if (lane_res[i] > lim_pos)      clamped[i] = lim_pos;
         else if (lane_res[i] < lim_neg) clamped[i] = lim_neg;
         else                            clamped[i] = lane_res[i];
         speed_out[i] = (kind == KIND_INVERSE) ? clamped[i][31:0] : '0;
      end
      for (int j = 0; j < 3; j++) begin
         if (lane_res[j] > S32_MAX)      sat[j] = S32_MAX;
         else if (lane_res[j] < S32_MIN) sat[j] = S32_MIN;
         else                            sat[j] = lane_res[j];
         est_out[j] = (kind == KIND_FORWARD) ? sat[j][31:0] : '0;
      end
   end

endmodule
`default_nettype wire
